/* hdl/ubx_pkg.sv */
// Shared types for the UBX frame parser: configuration bundle and result word.
`timescale 1ns / 1ps

package ubx_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SYNC_FIRST  = 3'd0;
  localparam logic [2:0] CFG_SYNC_SECOND = 3'd1;
  localparam logic [2:0] CFG_NAV_CLS     = 3'd2;
  localparam logic [2:0] CFG_LLH_ID      = 3'd3;
  localparam logic [2:0] CFG_VELNED_ID   = 3'd4;
  localparam logic [2:0] CFG_SOL_ID      = 3'd5;
  localparam logic [2:0] CFG_SVINFO_ID   = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] RST_SYNC_SECOND = 8'h62;
  localparam logic [7:0] RST_NAV_CLS     = 8'h01;
  localparam logic [7:0] RST_LLH_ID      = 8'h02;
  localparam logic [7:0] RST_VELNED_ID   = 8'h12;
  localparam logic [7:0] RST_SOL_ID      = 8'h06;
  localparam logic [7:0] RST_SVINFO_ID   = 8'h30;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] nav_cls;
    logic [7:0] llh_id;
    logic [7:0] velned_id;
    logic [7:0] sol_id;
    logic [7:0] svinfo_id;
  } cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] bytes_remaining;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic        frame_good;
    logic [3:0]  nav_flag_bits;
  } result_t;

endpackage

/* hdl/ubx_cfg_regs.sv */
// Configuration register file of the UBX frame parser.
`timescale 1ns / 1ps

module ubx_cfg_regs
  import ubx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [7:0] wr_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  // Write one register per accepted word; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= RST_SYNC_FIRST;
      cfg_r.sync_second <= RST_SYNC_SECOND;
      cfg_r.nav_cls     <= RST_NAV_CLS;
      cfg_r.llh_id      <= RST_LLH_ID;
      cfg_r.velned_id   <= RST_VELNED_ID;
      cfg_r.sol_id      <= RST_SOL_ID;
      cfg_r.svinfo_id   <= RST_SVINFO_ID;
    end else if (wr_en) begin
      case (wr_index)
        CFG_SYNC_FIRST:  cfg_r.sync_first  <= wr_data;
        CFG_SYNC_SECOND: cfg_r.sync_second <= wr_data;
        CFG_NAV_CLS:     cfg_r.nav_cls     <= wr_data;
        CFG_LLH_ID:      cfg_r.llh_id      <= wr_data;
        CFG_VELNED_ID:   cfg_r.velned_id   <= wr_data;
        CFG_SOL_ID:      cfg_r.sol_id      <= wr_data;
        CFG_SVINFO_ID:   cfg_r.svinfo_id   <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/ubx_parse_core.sv */
// Frame state machine and Fletcher-8 checksum of the UBX frame parser.
`timescale 1ns / 1ps

module ubx_parse_core
  import ubx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LENLO   = 4'd4;
  localparam logic [3:0] PH_LENHI   = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CKA     = 4'd7;
  localparam logic [3:0] PH_CKB     = 4'd8;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  sum_a_add;
  logic [15:0] len_full;
  logic [15:0] len_dec;
  logic [3:0]  flags;

  assign sum_a_add = sum_a_r + rx_byte;
  assign len_full  = {rx_byte, len_r[7:0]};
  assign len_dec   = len_r - 16'd1;

  // Flag bits for a navigation frame, one per matching id register.
  always_comb begin
    flags = 4'd0;
    if (class_r == cfg.nav_cls) begin
      flags[3] = (id_r == cfg.svinfo_id);
      flags[2] = (id_r == cfg.sol_id);
      flags[1] = (id_r == cfg.llh_id);
      flags[0] = (id_r == cfg.velned_id);
    end
  end

  // Next phase and field capture for the incoming byte.
  always_comb begin
    phase_nxt = PH_SYNC1;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    res       = '0;
    case (phase_r)
      PH_SYNC1: begin
        phase_nxt = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
      end
      PH_SYNC2: begin
        phase_nxt = (rx_byte == cfg.sync_second) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        class_nxt = rx_byte;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        len_nxt   = {8'd0, rx_byte};
        phase_nxt = PH_LENHI;
      end
      PH_LENHI: begin
        len_nxt   = len_full;
        phase_nxt = (len_full == 16'd0) ? PH_CKA : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res.payload_valid   = 1'b1;
        res.payload_byte    = rx_byte;
        res.bytes_remaining = len_r;
        len_nxt             = len_dec;
        phase_nxt           = (len_dec == 16'd0) ? PH_CKA : PH_PAYLOAD;
      end
      PH_CKA: begin
        phase_nxt = (rx_byte == sum_a_r) ? PH_CKB : PH_SYNC1;
      end
      PH_CKB: begin
        if (rx_byte == sum_b_r) begin
          res.frame_good    = 1'b1;
          res.nav_flag_bits = flags;
        end
        phase_nxt = PH_SYNC1;
      end
      default: begin
        phase_nxt = PH_SYNC1;
      end
    endcase
    res.frame_class = class_nxt;
    res.frame_id    = id_nxt;
  end

  // The checksum covers bytes from class through payload; a resync clears it.
  always_comb begin
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    if (phase_nxt >= PH_ID && phase_nxt <= PH_CKA) begin
      sum_a_nxt = sum_a_add;
      sum_b_nxt = sum_b_r + sum_a_add;
    end else if (phase_nxt == PH_SYNC1) begin
      sum_a_nxt = 8'd0;
      sum_b_nxt = 8'd0;
    end
  end

  // Parser state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      class_r <= 8'd0;
      id_r    <= 8'd0;
      len_r   <= 16'd0;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

endmodule

/* hdl/ubx_out_reg.sv */
// Result register of the UBX frame parser, refilled in the cycle it empties.
`timescale 1ns / 1ps

module ubx_out_reg
  import ubx_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    can_load,
  output result_t res_out
);

  logic    valid_r;
  result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  // Valid flag: set on load, cleared when the word is taken without a new one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

/* hdl/ubx_frame_parser.sv */
// Top level of the UBX frame parser.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_rx_byte
//   out_     output     out_valid / out_ready result fields, one word per input byte
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// The state machine and checksum update in the cycle an input byte is accepted and
// its result lands in the output register.
// One byte per cycle is sustained while out_ready is high; a stall on the output
// holds in_ready low only while the output register is full and not taken.
// Synchronous active-low reset returns the parser to sync hunting and loads the
// default register values. Configuration writes are always accepted.
`timescale 1ns / 1ps

module ubx_frame_parser
  import ubx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_bytes_remaining,
  output logic [7:0]  out_frame_class,
  output logic [7:0]  out_frame_id,
  output logic        out_frame_good,
  output logic [3:0]  out_nav_flag_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t    cfg;
  result_t step_res;
  result_t res_q;
  logic    can_load;
  logic    step_en;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_load;
  assign step_en   = in_valid && can_load;

  ubx_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ubx_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .rx_byte (in_rx_byte),
    .cfg     (cfg),
    .res     (step_res)
  );

  ubx_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .res_in    (step_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .res_out   (res_q)
  );

  // Result word fields onto their ports.
  assign out_payload_valid   = res_q.payload_valid;
  assign out_payload_byte    = res_q.payload_byte;
  assign out_bytes_remaining = res_q.bytes_remaining;
  assign out_frame_class     = res_q.frame_class;
  assign out_frame_id        = res_q.frame_id;
  assign out_frame_good      = res_q.frame_good;
  assign out_nav_flag_bits   = res_q.nav_flag_bits;

endmodule
